/* hw/rtl/bpa_pkg.sv */
// Shared constants, codes and types of the buffer pool allocator.
package bpa_pkg;

  // Pool geometry
  localparam int NUM_BUFFERS = 256;
  localparam int MAX_WAITERS = 16;
  localparam int MAX_RESULTS = 16;

  // Fixed field widths
  localparam int TYPE_W = 3;
  localparam int KIND_W = 3;
  localparam int ID_W   = 8;
  localparam int CNT_FW = 9;

  // Derived widths
  localparam int FREE_AW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int LVL_W   = $clog2(NUM_BUFFERS + 1);
  localparam int WAIT_AW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int WLVL_W  = $clog2(MAX_WAITERS + 1);
  localparam int RES_W   = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
  localparam int STAT_W  = (LVL_W > CNT_FW) ? LVL_W : CNT_FW;

  // Budget after reset
  localparam logic [CNT_FW-1:0] MAX_BUF_RST = CNT_FW'(256);

  typedef enum logic [TYPE_W-1:0] {
    REQ_ACQUIRE  = 3'd0,
    REQ_RELEASE  = 3'd1,
    REQ_STOP     = 3'd2,
    REQ_PREALLOC = 3'd3,
    REQ_STAT     = 3'd4
  } req_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_GRANT    = 3'd0,
    KIND_NULL     = 3'd1,
    KIND_PARKED   = 3'd2,
    KIND_HANDOFF  = 3'd3,
    KIND_WAKE     = 3'd4,
    KIND_PREALLOC = 3'd5,
    KIND_REJECT   = 3'd6,
    KIND_STAT     = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_STOP,
    ST_PREALLOC
  } state_e;

  typedef enum logic {
    SRC_FREE,
    SRC_WAITER
  } rd_src_e;

  // One result word as held in the output register
  typedef struct packed {
    logic              valid;
    kind_e             kind;
    logic [ID_W-1:0]   target;
    logic [ID_W-1:0]   gbuf;
    logic [CNT_FW-1:0] count;
    logic [CNT_FW-1:0] outs;
    logic [CNT_FW-1:0] cap;
    logic              last;
  } res_t;

endpackage

/* hw/rtl/bpa_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/buffer_pool_allocator_with_waiters_core.sv */
// Buffer pool allocator: free list and waiter queue in RAM, request sequencer.
// A word that needs no RAM read comes straight from the result register; one that does (free-list
// grant, handoff, first stop wake) passes through the RAM read register first; later wakes follow
// one a cycle. Prealloc answers after its free-list writes (one free-list write a cycle). A request
// is taken only while idle (busy low). Results cannot be stalled. Async active-low reset clears
// pointers, levels, counts, stopping flag; budget 256; RAMs keep contents.
module buffer_pool_allocator_with_waiters_core
  import bpa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // request channel
  input  logic              start,
  output logic              busy,
  input  logic [TYPE_W-1:0] req_type_i,
  input  logic [ID_W-1:0]   requester_id_i,
  input  logic [ID_W-1:0]   buffer_id_i,
  input  logic              buffer_valid_i,
  input  logic [CNT_FW-1:0] prealloc_count_i,
  // budget register write channel
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CNT_FW-1:0] cfg_data_i,
  // result channel
  output logic              result_valid_o,
  output logic [KIND_W-1:0] result_kind_o,
  output logic [ID_W-1:0]   target_requester_o,
  output logic [ID_W-1:0]   granted_buffer_o,
  output logic [CNT_FW-1:0] count_value_o,
  output logic [CNT_FW-1:0] outstanding_count_o,
  output logic [CNT_FW-1:0] capacity_left_o,
  output logic              last_result_o
);

  state_e              state_q, state_d;
  logic [CNT_FW-1:0]   max_buf_q, max_buf_d;
  logic [FREE_AW-1:0]  free_head_q, free_head_d;
  logic [FREE_AW-1:0]  free_tail_q, free_tail_d;
  logic [LVL_W-1:0]    free_level_q, free_level_d;
  logic [LVL_W-1:0]    created_q, created_d;
  logic [WAIT_AW-1:0]  wait_head_q, wait_head_d;
  logic [WAIT_AW-1:0]  wait_tail_q, wait_tail_d;
  logic [WLVL_W-1:0]   wait_level_q, wait_level_d;
  logic                stop_q, stop_d;
  logic [RES_W-1:0]    nres_q, nres_d;
  res_t                res_q, res_d;

  // held request payload
  logic [ID_W-1:0]     pend_req_q, pend_req_d;
  logic [ID_W-1:0]     pend_buf_q, pend_buf_d;
  rd_src_e             src_q, src_d;
  logic [CNT_FW-1:0]   pcount_q, pcount_d;
  logic [LVL_W-1:0]    made_q, made_d;

  // RAM ports
  logic                free_we;
  logic [FREE_AW-1:0]  free_waddr, free_raddr;
  logic [ID_W-1:0]     free_wdata, free_rdata;
  logic                wait_we;
  logic [WAIT_AW-1:0]  wait_waddr, wait_raddr;
  logic [ID_W-1:0]     wait_wdata, wait_rdata;

  logic                accept;
  logic                can_create;
  logic                stop_last;
  logic [LVL_W-1:0]    outs_w;
  logic [STAT_W-1:0]   cap_w;

  function automatic logic [FREE_AW-1:0] free_next(input logic [FREE_AW-1:0] p);
    return (p == FREE_AW'(NUM_BUFFERS - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [WAIT_AW-1:0] wait_next(input logic [WAIT_AW-1:0] p);
    return (p == WAIT_AW'(MAX_WAITERS - 1)) ? '0 : p + 1'b1;
  endfunction

  // result word without stat fields
  function automatic res_t mk_res(input kind_e k, input logic [ID_W-1:0] tgt,
                                  input logic [ID_W-1:0] gb, input logic [CNT_FW-1:0] cnt,
                                  input logic lst);
    res_t r;
    r.valid  = 1'b1;
    r.kind   = k;
    r.target = tgt;
    r.gbuf   = gb;
    r.count  = cnt;
    r.outs   = '0;
    r.cap    = '0;
    r.last   = lst;
    return r;
  endfunction

  // Free list and waiter queue storage
  bpa_ram #(.WIDTH(ID_W), .DEPTH(NUM_BUFFERS)) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (free_we),
    .waddr_i (free_waddr),
    .wdata_i (free_wdata),
    .raddr_i (free_raddr),
    .rdata_o (free_rdata)
  );

  bpa_ram #(.WIDTH(ID_W), .DEPTH(MAX_WAITERS)) u_wait_ram (
    .clk_i   (clk_i),
    .we_i    (wait_we),
    .waddr_i (wait_waddr),
    .wdata_i (wait_wdata),
    .raddr_i (wait_raddr),
    .rdata_o (wait_rdata)
  );

  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign accept      = start && !busy;
  assign can_create  = (created_q < max_buf_q) && (created_q < NUM_BUFFERS);
  assign stop_last   = (wait_level_q == WLVL_W'(1)) || (nres_q == RES_W'(MAX_RESULTS - 1));

  // stat: outstanding and capacity, both saturating at zero
  assign outs_w = (created_q > free_level_q) ? created_q - free_level_q : '0;
  assign cap_w  = (STAT_W'(max_buf_q) > STAT_W'(outs_w)) ?
                  STAT_W'(max_buf_q) - STAT_W'(outs_w) : '0;

  // Sequencer: next state, pointer updates, RAM accesses and result word
  always_comb begin
    state_d      = state_q;
    max_buf_d    = max_buf_q;
    free_head_d  = free_head_q;
    free_tail_d  = free_tail_q;
    free_level_d = free_level_q;
    created_d    = created_q;
    wait_head_d  = wait_head_q;
    wait_tail_d  = wait_tail_q;
    wait_level_d = wait_level_q;
    stop_d       = stop_q;
    nres_d       = nres_q;
    pend_req_d   = pend_req_q;
    pend_buf_d   = pend_buf_q;
    src_d        = src_q;
    pcount_d     = pcount_q;
    made_d       = made_q;
    res_d        = res_q;
    res_d.valid  = 1'b0;

    free_we    = 1'b0;
    free_waddr = free_tail_q;
    free_wdata = ID_W'(created_q);
    free_raddr = free_head_q;
    wait_we    = 1'b0;
    wait_waddr = wait_tail_q;
    wait_wdata = requester_id_i;
    wait_raddr = wait_head_q;

    if (cfg_valid_i && cfg_ready_o) begin
      max_buf_d = cfg_data_i;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_e'(req_type_i))
            REQ_ACQUIRE: begin
              if ((free_level_q == '0) && can_create) begin
                // new buffer passes straight through the empty list
                res_d       = mk_res(KIND_GRANT, requester_id_i, ID_W'(created_q), '0, 1'b1);
                created_d   = created_q + 1'b1;
                free_head_d = free_next(free_head_q);
                free_tail_d = free_next(free_tail_q);
              end else if (free_level_q != '0) begin
                free_head_d  = free_next(free_head_q);
                free_level_d = free_level_q - 1'b1;
                pend_req_d   = requester_id_i;
                src_d        = SRC_FREE;
                state_d      = ST_RD_WAIT;
              end else if (stop_q) begin
                res_d = mk_res(KIND_NULL, requester_id_i, '0, '0, 1'b1);
              end else if (wait_level_q >= MAX_WAITERS) begin
                res_d = mk_res(KIND_REJECT, requester_id_i, '0, '0, 1'b1);
              end else begin
                wait_we      = 1'b1;
                wait_tail_d  = wait_next(wait_tail_q);
                wait_level_d = wait_level_q + 1'b1;
                res_d        = mk_res(KIND_PARKED, requester_id_i, '0, '0, 1'b1);
              end
            end
            REQ_RELEASE: begin
              if (buffer_valid_i) begin
                if (wait_level_q != '0) begin
                  wait_head_d  = wait_next(wait_head_q);
                  wait_level_d = wait_level_q - 1'b1;
                  pend_buf_d   = buffer_id_i;
                  src_d        = SRC_WAITER;
                  state_d      = ST_RD_WAIT;
                end else if (free_level_q < NUM_BUFFERS) begin
                  free_we      = 1'b1;
                  free_wdata   = buffer_id_i;
                  free_tail_d  = free_next(free_tail_q);
                  free_level_d = free_level_q + 1'b1;
                end
              end
            end
            REQ_STOP: begin
              stop_d = 1'b1;
              if (wait_level_q != '0) begin
                nres_d  = '0;
                state_d = ST_STOP;
              end
            end
            REQ_PREALLOC: begin
              pcount_d = prealloc_count_i;
              made_d   = '0;
              state_d  = ST_PREALLOC;
            end
            REQ_STAT: begin
              res_d       = mk_res(KIND_STAT, '0, '0, CNT_FW'(free_level_q), 1'b1);
              res_d.outs  = CNT_FW'(outs_w);
              res_d.cap   = CNT_FW'(cap_w);
            end
            default: ;
          endcase
        end
      end
      ST_RD_WAIT: begin
        // read word of the popped entry is ready
        state_d = ST_IDLE;
        if (src_q == SRC_FREE) begin
          res_d = mk_res(KIND_GRANT, pend_req_q, free_rdata, '0, 1'b1);
        end else begin
          res_d = mk_res(KIND_HANDOFF, wait_rdata, pend_buf_q, '0, 1'b1);
        end
      end
      ST_STOP: begin
        // wake one waiter a cycle, read of the next one issued alongside
        res_d        = mk_res(KIND_WAKE, wait_rdata, '0, '0, stop_last);
        wait_head_d  = wait_next(wait_head_q);
        wait_level_d = wait_level_q - 1'b1;
        nres_d       = nres_q + 1'b1;
        wait_raddr   = wait_next(wait_head_q);
        if (stop_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_PREALLOC: begin
        if ((made_q < pcount_q) && can_create && (free_level_q < NUM_BUFFERS)) begin
          free_we      = 1'b1;
          free_tail_d  = free_next(free_tail_q);
          free_level_d = free_level_q + 1'b1;
          created_d    = created_q + 1'b1;
          made_d       = made_q + 1'b1;
        end else begin
          res_d   = mk_res(KIND_PREALLOC, '0, '0, CNT_FW'(made_q), 1'b1);
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      max_buf_q    <= MAX_BUF_RST;
      free_head_q  <= '0;
      free_tail_q  <= '0;
      free_level_q <= '0;
      created_q    <= '0;
      wait_head_q  <= '0;
      wait_tail_q  <= '0;
      wait_level_q <= '0;
      stop_q       <= 1'b0;
      nres_q       <= '0;
      res_q        <= '0;
    end else begin
      state_q      <= state_d;
      max_buf_q    <= max_buf_d;
      free_head_q  <= free_head_d;
      free_tail_q  <= free_tail_d;
      free_level_q <= free_level_d;
      created_q    <= created_d;
      wait_head_q  <= wait_head_d;
      wait_tail_q  <= wait_tail_d;
      wait_level_q <= wait_level_d;
      stop_q       <= stop_d;
      nres_q       <= nres_d;
      res_q        <= res_d;
    end
  end

  // Held request payload
  always_ff @(posedge clk_i) begin
    pend_req_q <= pend_req_d;
    pend_buf_q <= pend_buf_d;
    src_q      <= src_d;
    pcount_q   <= pcount_d;
    made_q     <= made_d;
  end

  assign result_valid_o      = res_q.valid;
  assign result_kind_o       = res_q.kind;
  assign target_requester_o  = res_q.target;
  assign granted_buffer_o    = res_q.gbuf;
  assign count_value_o       = res_q.count;
  assign outstanding_count_o = res_q.outs;
  assign capacity_left_o     = res_q.cap;
  assign last_result_o       = res_q.last;

`ifndef NO_ASSERTIONS
  // a pending RAM read always ends in a result word
  a_rd_wait_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD_WAIT) |=> (result_valid_o && last_result_o))
    else $error("read wait did not produce a result");

  // levels stay within the queue depths
  a_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_level_q <= NUM_BUFFERS) && (wait_level_q <= MAX_WAITERS))
    else $error("queue level out of range");

  // a stat query answers in the next cycle with a single stat word
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_type_i == REQ_STAT)) |=>
      (result_valid_o && last_result_o && (result_kind_o == KIND_STAT)))
    else $error("stat query not answered");

  // nothing is emitted while the sequencer sits idle without a request
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_IDLE) && !start) |=> !result_valid_o)
    else $error("result word without a request");
`endif

endmodule
